/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: label");

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition: label");

`endif

/* src/hffs_pkg.sv */
// Shared types and constants of the haptic force feedback shaper.
package hffs_pkg;

	// Datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_PHASE,
		OP_Z,
		OP_Z2,
		OP_P1,
		OP_P2,
		OP_P3,
		OP_S,
		OP_VIB,
		OP_X,
		OP_W0,
		OP_W1,
		OP_NORM,
		OP_MINIT,
		OP_SQ,
		OP_LN,
		OP_CMD,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic norm_done;
		logic sq_last;
	} dp_status_t;

	// Register indexes
	localparam logic [2:0] REG_THRESHOLD  = 3'd0;
	localparam logic [2:0] REG_VIB_BASE   = 3'd1;
	localparam logic [2:0] REG_VIB_RATIO  = 3'd2;
	localparam logic [2:0] REG_PHASE_STEP = 3'd3;
	localparam logic [2:0] REG_FB_RATIO   = 3'd4;
	localparam logic [2:0] REG_OFFSET     = 3'd5;
	localparam logic [2:0] REG_LOG_GAIN   = 3'd6;
	localparam logic [2:0] REG_LOG_IN     = 3'd7;

	// Register reset values
	localparam logic [15:0] RST_THRESHOLD  = 16'd256;
	localparam logic [15:0] RST_VIB_BASE   = 16'd26;
	localparam logic [15:0] RST_VIB_RATIO  = 16'd6554;
	localparam logic [31:0] RST_PHASE_STEP = 32'd644245;
	localparam logic [15:0] RST_FB_RATIO   = 16'd6554;
	localparam logic [15:0] RST_OFFSET     = 16'd51;
	localparam logic [15:0] RST_LOG_GAIN   = 16'd4096;
	localparam logic [15:0] RST_LOG_IN     = 16'd2458;

	// Sine polynomial coefficients (Q16) and ln 2 (Q16)
	localparam logic [16:0] SIN_C0 = 17'd102944;
	localparam logic [16:0] SIN_C1 = 17'd42334;
	localparam logic [16:0] SIN_C2 = 17'd5223;
	localparam logic [16:0] SIN_C3 = 17'd307;
	localparam logic [16:0] LN2_Q16 = 17'd45426;
	localparam logic [23:0] CMD_MAX = 24'd32768;

endpackage

/* src/hffs_if.sv */
// Stream and configuration channel interfaces of the shaper.
interface hffs_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] force_sample;
	logic        [31:0] time_us;
	modport source (output valid, output force_sample, output time_us, input ready);
	modport sink (input valid, input force_sample, input time_us, output ready);
endinterface

interface hffs_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] command;
	logic        contact;
	modport source (output valid, output command, output contact, input ready);
	modport sink (input valid, input command, input contact, output ready);
endinterface

interface hffs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* src/hffs_ctrl.sv */
// Controller sequencing the shaper datapath one sample at a time.
module hffs_ctrl
	import hffs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_PHASE, ST_Z, ST_Z2, ST_P1, ST_P2, ST_P3, ST_S, ST_VIB, ST_X,
		ST_W0, ST_W1, ST_NORM, ST_MINIT, ST_SQ, ST_LN, ST_CMD, ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Map state to datapath operation
	always_comb begin
		unique case (state_q)
			ST_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
			ST_PHASE: cmd.op = OP_PHASE;
			ST_Z:     cmd.op = OP_Z;
			ST_Z2:    cmd.op = OP_Z2;
			ST_P1:    cmd.op = OP_P1;
			ST_P2:    cmd.op = OP_P2;
			ST_P3:    cmd.op = OP_P3;
			ST_S:     cmd.op = OP_S;
			ST_VIB:   cmd.op = OP_VIB;
			ST_X:     cmd.op = OP_X;
			ST_W0:    cmd.op = OP_W0;
			ST_W1:    cmd.op = OP_W1;
			ST_NORM:  cmd.op = OP_NORM;
			ST_MINIT: cmd.op = OP_MINIT;
			ST_SQ:    cmd.op = OP_SQ;
			ST_LN:    cmd.op = OP_LN;
			ST_CMD:   cmd.op = OP_CMD;
			ST_DONE:  cmd.op = slot_free ? OP_OUT : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	// Advance state and hold the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Raise the flag on completion, drop it after the transfer
			if (state_q == ST_DONE && slot_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_PHASE;
				ST_PHASE: state_q <= ST_Z;
				ST_Z:     state_q <= ST_Z2;
				ST_Z2:    state_q <= ST_P1;
				ST_P1:    state_q <= ST_P2;
				ST_P2:    state_q <= ST_P3;
				ST_P3:    state_q <= ST_S;
				ST_S:     state_q <= ST_VIB;
				ST_VIB:   state_q <= ST_X;
				ST_X:     state_q <= ST_W0;
				ST_W0:    state_q <= ST_W1;
				ST_W1:    state_q <= ST_NORM;
				ST_NORM:  if (status.norm_done) state_q <= ST_MINIT;
				ST_MINIT: state_q <= ST_SQ;
				ST_SQ:    if (status.sq_last) state_q <= ST_LN;
				ST_LN:    state_q <= ST_CMD;
				ST_CMD:   state_q <= ST_DONE;
				ST_DONE:  if (slot_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* src/hffs_datapath.sv */
// Datapath of the shaper: registers, contact tracking, sine, scaling and log.
module hffs_datapath
	import hffs_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 256
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	input  logic signed [15:0] force_sample,
	input  logic        [31:0] time_us,
	input  logic               cfg_we,
	input  logic        [2:0]  cfg_index,
	input  logic        [31:0] cfg_data,
	output logic        [15:0] command,
	output logic               contact
);

	localparam int SINE_AW = $clog2(SINE_TABLE_DEPTH);

	// Configuration registers
	logic signed [15:0] thr_q, base_q, off_q;
	logic        [15:0] vratio_q, fb_q, a_q, b_q;
	logic        [31:0] step_q;

	// Sample state
	logic signed [15:0] prev_q;
	logic               contact_q, started_q;
	logic        [31:0] start_q;

	// Working registers
	logic signed [15:0] f_q;
	logic        [31:0] elapsed_q, phase_q;
	logic signed [17:0] amp_q;
	logic        [16:0] z_q, z2_q, p_q;
	logic               neg_q;
	logic signed [16:0] sine_q;
	logic signed [19:0] vib_q;
	logic        [28:0] x_q;
	logic        [31:0] acc_q;
	logic        [33:0] n_q;
	logic        [4:0]  scnt_q;
	logic        [30:0] m_q;
	logic        [15:0] frac_q;
	logic        [3:0]  it_q;
	logic        [20:0] l_q;
	logic        [15:0] cmd_q;
	logic        [15:0] out_cmd_q;
	logic               out_contact_q;

	// Contact detection on the incoming sample
	logic set_c, clr_c, new_c;
	assign set_c = (prev_q <= thr_q) && (force_sample > thr_q);
	assign clr_c = (force_sample < thr_q);
	assign new_c = set_c ? 1'b1 : (clr_c ? 1'b0 : contact_q);

	// Phase and amplitude
	logic        [31:0] ph_mul;
	logic signed [32:0] rf_mul;
	assign ph_mul = elapsed_q * step_q;
	assign rf_mul = $signed({1'b0, vratio_q}) * f_q;

	// Quarter-wave fold of the table index
	logic [SINE_AW-1:0] idx;
	logic [15:0]        u, r;
	assign idx = phase_q[31 -: SINE_AW];
	assign u   = {idx, {(16 - SINE_AW){1'b0}}};
	assign r   = {u[13:0], 2'b00};

	// Polynomial products
	logic [33:0] z2_mul, p_mul, s_mul;
	logic [16:0] p_op, p_k;
	assign z2_mul = z_q * z_q;
	assign p_op   = (cmd.op == OP_P1) ? SIN_C3 : p_q;
	assign p_mul  = z2_q * p_op;
	assign s_mul  = z_q * p_q;
	always_comb begin
		case (cmd.op)
			OP_P1:   p_k = SIN_C2;
			OP_P2:   p_k = SIN_C1;
			default: p_k = SIN_C0;
		endcase
	end

	// Vibration and scaling
	logic signed [34:0] v_mul;
	logic signed [20:0] sum;
	logic signed [37:0] x_mul;
	assign v_mul = amp_q * sine_q;
	assign sum   = 21'(f_q) + 21'(vib_q) + 21'(off_q);
	assign x_mul = $signed({1'b0, fb_q}) * sum;

	// Log input product in two halves
	logic [31:0] w_lo;
	logic [28:0] w_hi;
	logic [44:0] w_tot;
	assign w_lo  = b_q * x_q[15:0];
	assign w_hi  = b_q * x_q[28:16];
	assign w_tot = {w_hi, 16'd0} + {13'd0, acc_q};

	// Squaring step and final products
	logic [61:0] m_mul;
	logic [31:0] m2;
	logic [4:0]  e_off;
	logic [36:0] l_mul, c_mul;
	logic [23:0] c_val;
	assign m_mul = m_q * m_q;
	assign m2    = m_mul[61:30];
	assign e_off = 5'd17 - scnt_q;
	assign l_mul = {e_off, frac_q} * LN2_Q16;
	assign c_mul = a_q * l_q;
	assign c_val = c_mul[36:13];

	assign status.norm_done = n_q[33];
	assign status.sq_last   = (it_q == 4'd15);
	assign command = out_cmd_q;
	assign contact = out_contact_q;

	// Write configuration and hold sample state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= RST_THRESHOLD;
			base_q    <= RST_VIB_BASE;
			vratio_q  <= RST_VIB_RATIO;
			step_q    <= RST_PHASE_STEP;
			fb_q      <= RST_FB_RATIO;
			off_q     <= RST_OFFSET;
			a_q       <= RST_LOG_GAIN;
			b_q       <= RST_LOG_IN;
			prev_q    <= '0;
			contact_q <= 1'b0;
			started_q <= 1'b0;
			start_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_THRESHOLD:  thr_q    <= cfg_data[15:0];
					REG_VIB_BASE:   base_q   <= cfg_data[15:0];
					REG_VIB_RATIO:  vratio_q <= cfg_data[15:0];
					REG_PHASE_STEP: step_q   <= cfg_data;
					REG_FB_RATIO:   fb_q     <= cfg_data[15:0];
					REG_OFFSET:     off_q    <= cfg_data[15:0];
					REG_LOG_GAIN:   a_q      <= cfg_data[15:0];
					REG_LOG_IN:     b_q      <= cfg_data[15:0];
					default:        ;
				endcase
			end
			if (cmd.op == OP_LOAD) begin
				prev_q    <= force_sample;
				contact_q <= new_c;
				if (new_c && !started_q) begin
					started_q <= 1'b1;
					start_q   <= time_us;
				end
			end
		end
	end

	// Step the datapath on each operation
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				f_q       <= force_sample;
				elapsed_q <= (new_c && !started_q) ? 32'd0 : time_us - start_q;
			end
			OP_PHASE: begin
				phase_q <= ph_mul;
				amp_q   <= 18'(base_q) + 18'($signed(rf_mul[32:16]));
			end
			OP_Z: begin
				z_q   <= u[14] ? (17'd65536 - {1'b0, r}) : {1'b0, r};
				neg_q <= u[15];
			end
			OP_Z2: z2_q <= z2_mul[32:16];
			OP_P1, OP_P2, OP_P3: p_q <= p_k - p_mul[32:16];
			OP_S: sine_q <= neg_q ? -$signed(s_mul[33:17]) : $signed(s_mul[33:17]);
			OP_VIB: vib_q <= contact_q ? v_mul[34:15] : 20'sd0;
			OP_X: x_q <= x_mul[37] ? 29'd0 : x_mul[36:8];
			OP_W0: acc_q <= w_lo;
			OP_W1: begin
				n_q    <= 34'd65536 + {1'b0, w_tot[44:12]};
				scnt_q <= '0;
			end
			OP_NORM: begin
				if (!n_q[33]) begin
					n_q    <= {n_q[32:0], 1'b0};
					scnt_q <= scnt_q + 5'd1;
				end
			end
			OP_MINIT: begin
				m_q    <= n_q[33:3];
				frac_q <= '0;
				it_q   <= '0;
			end
			OP_SQ: begin
				frac_q <= {frac_q[14:0], m2[31]};
				m_q    <= m2[31] ? m2[31:1] : m2[30:0];
				it_q   <= it_q + 4'd1;
			end
			OP_LN: l_q <= l_mul[36:16];
			OP_CMD: cmd_q <= (c_val > CMD_MAX) ? CMD_MAX[15:0] : c_val[15:0];
			OP_OUT: begin
				out_cmd_q     <= cmd_q;
				out_contact_q <= contact_q;
			end
			default: ;
		endcase
	end

endmodule

/* src/haptic_force_feedback_shaper_top.sv */
// Haptic force feedback shaper: turns each force sample into a Q1.15 drive
// command and a contact flag. One sample is processed at a time; the time
// from transfer in to result valid is set by the sine polynomial steps, a
// leading-one search of one bit a cycle (up to 17 shifts), 16 squaring
// steps of the logarithm and the wait for a free output slot. A finished
// result waits in the output register while the next sample is taken.
// Configuration writes are accepted in every cycle and belong only in idle
// periods.
module haptic_force_feedback_shaper_top
	import hffs_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 256
)
(
	input  logic          clk,
	input  logic          arst_n,
	hffs_sample_if.sink   samples,
	hffs_result_if.source results,
	hffs_cfg_if.sink      cfg
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	assign cfg.ready = 1'b1;

	hffs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (dp_status),
		.cmd       (dp_cmd)
	);

	hffs_datapath #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.status       (dp_status),
		.force_sample (samples.force_sample),
		.time_us      (samples.time_us),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.command      (results.command),
		.contact      (results.contact)
	);

endmodule

/* src/hffs_checker.sv */
// Port-level checker of the shaper and its bind to the top level.
`include "assert_macros.svh"

module hffs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] command
);

	// Result held until transferred
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)
	// Command never exceeds full scale
	`ASSERT_NEVER(a_cmd_range, clk, arst_n, out_valid && (command > 16'd32768))
	// Busy in the cycle after a sample transfer
	`ASSERT_CLK(a_busy_after_in, clk, arst_n, in_valid && in_ready |=> !in_ready)

endmodule

bind haptic_force_feedback_shaper_top hffs_checker u_hffs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.command   (results.command)
);
